### rtl/bde_pkg.sv
// Shared types and constants of the button debounce and event detector.
`timescale 1ns / 1ps

package bde_pkg;

   // Fixed field widths
   localparam int CNT_W   = 16;
   localparam int DUR_W   = 32;
   localparam int IDX_W   = 3;
   localparam int MASK_W  = 6;
   localparam int CSR_W   = 16;
   localparam int CSR_A_W = 2;

   // Event codes carried in a result
   localparam logic [1:0] EV_PRESSED  = 2'd0;
   localparam logic [1:0] EV_RELEASED = 2'd1;
   localparam logic [1:0] EV_HELD     = 2'd2;
   localparam logic [1:0] EV_DOUBLE   = 2'd3;

   // Event slots of one lane, in emit order
   localparam logic [1:0] SLOT_PRESSED  = 2'd0;
   localparam logic [1:0] SLOT_DOUBLE   = 2'd1;
   localparam logic [1:0] SLOT_HELD     = 2'd2;
   localparam logic [1:0] SLOT_RELEASED = 2'd3;

   // Register indexes
   localparam logic [CSR_A_W-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_HOLD       = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_DBL_WINDOW = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_ACT_LOW    = 2'd3;

   // Thresholds seen by every lane
   typedef struct packed {
      logic [CNT_W-1:0] debounce_ticks;
      logic [CNT_W-1:0] hold_ticks;
      logic [CNT_W-1:0] double_click_ticks;
   } lane_cfg_type;

   // Events found by one lane in one tick; bit order matches the slots
   typedef struct packed {
      logic released;
      logic held;
      logic dbl_click;
      logic pressed;
   } lane_event_type;

   // One result item
   typedef struct packed {
      logic              event_valid;
      logic [IDX_W-1:0]  button_index;
      logic [1:0]        event_code;
      logic [DUR_W-1:0]  hold_duration;
      logic [MASK_W-1:0] pressed_mask;
      logic [MASK_W-1:0] held_mask;
      logic              last_of_tick;
   } rsp_type;

endpackage

### rtl/button_debounce_event_detector.sv
// Top level of the button debounce and event detector.
// Usage: each request on req_* is one tick carrying the raw pin level of every
// button. Per tick the block debounces all buttons in parallel lanes and then
// returns one or more results on rsp_*: one per event (pressed, double
// clicked, held, released), in button index order, or a single status result
// when nothing happened. Every result carries the pressed and held masks after
// the tick; last_of_tick marks the final one.
// Thresholds and polarity are written through csr_* while the block is idle.
// The events of a tick are latched when the request is taken; the merge stage
// then returns max(1, E) results, E being the event count (at most
// 3 * NUM_BUTTONS), loading one result per cycle unless the receiver stalls.
// req_ready drops from acceptance until the last result of the tick is in
// the output register; the next tick may be taken while that result waits.
// A stalled receiver holds the output register and pauses the merge stage.
// Reset releases all buttons, clears counters and stamps, and restores the
// register defaults (debounce 20, hold 1000, double click 300, all active low).
`timescale 1ns / 1ps

module button_debounce_event_detector #(
   parameter int NUM_BUTTONS = 6,
   parameter int TICK_WIDTH  = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bde_pkg::MASK_W-1:0]     req_pin_levels,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_event_valid,
   output logic [bde_pkg::IDX_W-1:0]      rsp_button_index,
   output logic [1:0]                     rsp_event_code,
   output logic [bde_pkg::DUR_W-1:0]      rsp_hold_duration,
   output logic [bde_pkg::MASK_W-1:0]     rsp_pressed_mask,
   output logic [bde_pkg::MASK_W-1:0]     rsp_held_mask,
   output logic                           rsp_last_of_tick,
   input  logic                           csr_we,
   input  logic [bde_pkg::CSR_A_W-1:0]    csr_index,
   input  logic [bde_pkg::CSR_W-1:0]      csr_wdata
);

   bde_pkg::lane_cfg_type                          cfg_ff;
   logic [bde_pkg::MASK_W-1:0]                     act_low_ff;
   logic [TICK_WIDTH-1:0]                          tick_ff, tick_in;
   logic                                           accept, busy;
   logic [NUM_BUTTONS-1:0]                         lane_level, lane_act_low;
   logic [NUM_BUTTONS-1:0]                         lane_pressed, lane_long;
   bde_pkg::lane_event_type [NUM_BUTTONS-1:0]      lane_events;
   logic [NUM_BUTTONS-1:0][bde_pkg::DUR_W-1:0]     lane_dur;
   logic [bde_pkg::MASK_W-1:0]                     pressed_mask, held_mask;
   bde_pkg::rsp_type                               rsp;

   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;
   assign tick_in   = tick_ff + 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= 16'd20;
         cfg_ff.hold_ticks         <= 16'd1000;
         cfg_ff.double_click_ticks <= 16'd300;
         act_low_ff                <= '1;
      end else if (csr_we) begin
         case (csr_index)
            bde_pkg::CSR_DEBOUNCE:   cfg_ff.debounce_ticks     <= csr_wdata;
            bde_pkg::CSR_HOLD:       cfg_ff.hold_ticks         <= csr_wdata;
            bde_pkg::CSR_DBL_WINDOW: cfg_ff.double_click_ticks <= csr_wdata;
            bde_pkg::CSR_ACT_LOW:    act_low_ff <= csr_wdata[bde_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the wrapping tick counter per request
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (accept) begin
         tick_ff <= tick_in;
      end
   end

   // Lanes beyond the pin field see a released, active-high pin
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      if (i < bde_pkg::MASK_W) begin : g_pin
         assign lane_level[i]   = req_pin_levels[i];
         assign lane_act_low[i] = act_low_ff[i];
      end else begin : g_nopin
         assign lane_level[i]   = 1'b0;
         assign lane_act_low[i] = 1'b0;
      end

      bde_lane #(
         .TICK_WIDTH(TICK_WIDTH)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .step       (accept),
         .level      (lane_level[i]),
         .active_low (lane_act_low[i]),
         .tick       (tick_in),
         .cfg        (cfg_ff),
         .events     (lane_events[i]),
         .duration   (lane_dur[i]),
         .pressed    (lane_pressed[i]),
         .long_press (lane_long[i])
      );
   end

   // Status masks cover the first six buttons
   for (genvar m = 0; m < bde_pkg::MASK_W; m++) begin : g_mask
      if (m < NUM_BUTTONS) begin : g_on
         assign pressed_mask[m] = lane_pressed[m];
         assign held_mask[m]    = lane_pressed[m] && lane_long[m];
      end else begin : g_off
         assign pressed_mask[m] = 1'b0;
         assign held_mask[m]    = 1'b0;
      end
   end

   bde_merge #(
      .NUM_BUTTONS(NUM_BUTTONS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .start        (accept),
      .events       (lane_events),
      .durations    (lane_dur),
      .pressed_mask (pressed_mask),
      .held_mask    (held_mask),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp),
      .busy         (busy)
   );

   assign rsp_event_valid   = rsp.event_valid;
   assign rsp_button_index  = rsp.button_index;
   assign rsp_event_code    = rsp.event_code;
   assign rsp_hold_duration = rsp.hold_duration;
   assign rsp_pressed_mask  = rsp.pressed_mask;
   assign rsp_held_mask     = rsp.held_mask;
   assign rsp_last_of_tick  = rsp.last_of_tick;

endmodule

### rtl/bde_lane.sv
// One button lane: polarity, debounce counter, press/release stamps and event flags.
`timescale 1ns / 1ps

module bde_lane #(
   parameter int TICK_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic                         level,
   input  logic                         active_low,
   input  logic [TICK_WIDTH-1:0]        tick,
   input  bde_pkg::lane_cfg_type        cfg,
   output bde_pkg::lane_event_type      events,
   output logic [bde_pkg::DUR_W-1:0]    duration,
   output logic                         pressed,
   output logic                         long_press
);

   logic [bde_pkg::CNT_W-1:0] count_ff, count_in, count_inc;
   logic                      stable_ff, stable_in;
   logic                      held_ff, held_in, held_mid;
   logic                      pending_ff, pending_in, pending_mid;
   logic [TICK_WIDTH-1:0]     press_stamp_ff, press_stamp_in;
   logic [TICK_WIDTH-1:0]     release_stamp_ff, release_stamp_in;
   logic [bde_pkg::DUR_W-1:0] dur_ff, dur_in;
   logic                      long_ff, long_in;

   logic                      cur, differ, change, is_press, is_release;
   logic [TICK_WIDTH-1:0]     since_press_old, since_press_new;
   logic [TICK_WIDTH-1:0]     since_rel_old, since_rel_new;
   logic [TICK_WIDTH-1:0]     hold_ext, window_ext;

   // Debounce and event decisions for this tick
   always_comb begin
      cur        = level ^ active_low;
      count_inc  = count_ff + 1'b1;
      differ     = cur != stable_ff;
      change     = differ && (count_inc >= cfg.debounce_ticks);
      is_press   = change && cur;
      is_release = change && !cur;

      since_press_old = tick - press_stamp_ff;
      since_rel_old   = tick - release_stamp_ff;
      since_press_new = is_press ? '0 : since_press_old;
      since_rel_new   = is_release ? '0 : since_rel_old;
      hold_ext        = TICK_WIDTH'(cfg.hold_ticks);
      window_ext      = TICK_WIDTH'(cfg.double_click_ticks);

      events.pressed   = is_press;
      events.dbl_click = is_press && pending_ff && (since_rel_old <= window_ext);
      // a release after a hold stays silent
      events.released  = is_release && !held_ff;

      held_mid = change ? 1'b0 : held_ff;
      if (is_press) begin
         pending_mid = pending_ff && !events.dbl_click;
      end else if (is_release) begin
         pending_mid = !held_ff;
      end else begin
         pending_mid = pending_ff;
      end

      stable_in   = change ? cur : stable_ff;
      long_in     = stable_in && (since_press_new >= hold_ext);
      events.held = long_in && !held_mid;
      held_in     = held_mid || events.held;

      // expire a click whose window has passed
      pending_in = pending_mid && !(since_rel_new > window_ext);

      count_in         = (change || !differ) ? '0 : count_inc;
      press_stamp_in   = is_press ? tick : press_stamp_ff;
      release_stamp_in = is_release ? tick : release_stamp_ff;

      if (events.released) begin
         dur_in = bde_pkg::DUR_W'(since_press_old);
      end else if (events.held) begin
         dur_in = bde_pkg::DUR_W'(since_press_new);
      end else begin
         dur_in = '0;
      end
   end

   // Advance lane state once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         stable_ff        <= 1'b0;
         held_ff          <= 1'b0;
         pending_ff       <= 1'b0;
         press_stamp_ff   <= '0;
         release_stamp_ff <= '0;
         long_ff          <= 1'b0;
      end else if (step) begin
         count_ff         <= count_in;
         stable_ff        <= stable_in;
         held_ff          <= held_in;
         pending_ff       <= pending_in;
         press_stamp_ff   <= press_stamp_in;
         release_stamp_ff <= release_stamp_in;
         long_ff          <= long_in;
      end
   end

   // Hold the event duration for the merge stage
   always_ff @(posedge clock) begin
      if (step) begin
         dur_ff <= dur_in;
      end
   end

   assign duration   = dur_ff;
   assign pressed    = stable_ff;
   assign long_press = long_ff;

endmodule

### rtl/bde_merge.sv
// Merge stage: serializes lane events in button order into the result register.
`timescale 1ns / 1ps

module bde_merge #(
   parameter int NUM_BUTTONS = 6
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  bde_pkg::lane_event_type [NUM_BUTTONS-1:0]     events,
   input  logic [NUM_BUTTONS-1:0][bde_pkg::DUR_W-1:0]    durations,
   input  logic [bde_pkg::MASK_W-1:0]                    pressed_mask,
   input  logic [bde_pkg::MASK_W-1:0]                    held_mask,
   input  logic                                          rsp_ready,
   output logic                                          rsp_valid,
   output bde_pkg::rsp_type                              rsp,
   output logic                                          busy
);

   localparam int BTN_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int FLAT_W = 4 * NUM_BUTTONS;

   logic [NUM_BUTTONS-1:0][3:0] pending_ff;
   logic [FLAT_W-1:0]           flat, rest;
   logic                        busy_ff, valid_ff, load;
   bde_pkg::rsp_type            rsp_ff, rsp_in;
   logic [BTN_W-1:0]            sel_btn;
   logic [1:0]                  sel_slot;

   // Find the first pending event, buttons in index order
   always_comb begin
      sel_btn  = '0;
      sel_slot = bde_pkg::SLOT_PRESSED;
      for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
         for (int s = 3; s >= 0; s--) begin
            if (pending_ff[b][s]) begin
               sel_btn  = BTN_W'(b);
               sel_slot = 2'(s);
            end
         end
      end
      flat = pending_ff;
      rest = flat & (flat - 1'b1);
   end

   // Build the next result
   always_comb begin
      rsp_in.pressed_mask  = pressed_mask;
      rsp_in.held_mask     = held_mask;
      rsp_in.event_valid   = |flat;
      rsp_in.button_index  = '0;
      rsp_in.event_code    = bde_pkg::EV_PRESSED;
      rsp_in.hold_duration = '0;
      rsp_in.last_of_tick  = ~|rest;
      if (|flat) begin
         rsp_in.button_index = bde_pkg::IDX_W'(sel_btn);
         case (sel_slot)
            bde_pkg::SLOT_PRESSED: begin
               rsp_in.event_code = bde_pkg::EV_PRESSED;
            end
            bde_pkg::SLOT_DOUBLE: begin
               rsp_in.event_code = bde_pkg::EV_DOUBLE;
            end
            bde_pkg::SLOT_HELD: begin
               rsp_in.event_code    = bde_pkg::EV_HELD;
               rsp_in.hold_duration = durations[sel_btn];
            end
            default: begin
               rsp_in.event_code    = bde_pkg::EV_RELEASED;
               rsp_in.hold_duration = durations[sel_btn];
            end
         endcase
      end
   end

   assign load = busy_ff && (!valid_ff || rsp_ready);

   // Latch events at accept, drop one per result loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         busy_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (start) begin
            pending_ff <= events;
            busy_ff    <= 1'b1;
         end else if (load) begin
            pending_ff <= rest;
            busy_ff    <= |rest;
         end
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;
   assign busy      = busy_ff;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the button debounce and event detector.
`timescale 1ns / 1ps

module tb_top;

   localparam int CNT_W   = bde_pkg::CNT_W;
   localparam int DUR_W   = bde_pkg::DUR_W;
   localparam int IDX_W   = bde_pkg::IDX_W;
   localparam int MASK_W  = bde_pkg::MASK_W;
   localparam int CSR_W   = bde_pkg::CSR_W;
   localparam int CSR_A_W = bde_pkg::CSR_A_W;

   typedef bde_pkg::rsp_type result_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   // One line of the directed plan: a tick or a register write
   typedef struct {
      row_kind_type       kind;
      logic [CSR_A_W-1:0] index;
      logic [CSR_W-1:0]   data;
      logic [MASK_W-1:0]  levels;
      bit                 fixed_status;
      logic [MASK_W-1:0]  pmask;
      logic [MASK_W-1:0]  hmask;
   } plan_row_type;

   localparam int NUM_ROWS       = 33;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int END_SETTLE     = 40;
   localparam int MAX_PRINTS     = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MASK_W-1:0]   req_pin_levels = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_event_valid;
   logic [IDX_W-1:0]    rsp_button_index;
   logic [1:0]          rsp_event_code;
   logic [DUR_W-1:0]    rsp_hold_duration;
   logic [MASK_W-1:0]   rsp_pressed_mask;
   logic [MASK_W-1:0]   rsp_held_mask;
   logic                rsp_last_of_tick;
   logic                csr_we = 1'b0;
   logic [CSR_A_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   // Predicted button state and thresholds
   logic [CNT_W-1:0]    cfg_debounce = 16'd20;
   logic [CNT_W-1:0]    cfg_hold = 16'd1000;
   logic [CNT_W-1:0]    cfg_window = 16'd300;
   logic [MASK_W-1:0]   cfg_act_low = 6'h3F;
   logic [DUR_W-1:0]    now_tick = '0;
   logic [CNT_W-1:0]    bounce_cnt [MASK_W] = '{default: '0};
   bit                  is_pressed [MASK_W] = '{default: 1'b0};
   bit                  held_seen [MASK_W] = '{default: 1'b0};
   bit                  click_open [MASK_W] = '{default: 1'b0};
   logic [DUR_W-1:0]    press_tick [MASK_W] = '{default: '0};
   logic [DUR_W-1:0]    release_tick [MASK_W] = '{default: '0};

   result_type          tick_events[$];
   result_type          awaited_events[$];
   int                  ticks_sent = 0;
   int                  ticks_done = 0;
   int                  err_count = 0;
   int                  quiet_cycles = 0;
   bit                  calm = 1'b0;

   plan_row_type plan [NUM_ROWS] = '{
      // defaults after reset: all released, one pressed sample is not enough
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h3F, 1'b1, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h00, 1'b1, 6'h00, 6'h00},
      // zero debounce, widest windows, active high
      '{ROW_CSR,  bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h00, 1'b0, 6'h00, 6'h00},
      '{ROW_CSR,  bde_pkg::CSR_HOLD,       16'd65535, 6'h00, 1'b0, 6'h00, 6'h00},
      '{ROW_CSR,  bde_pkg::CSR_DBL_WINDOW, 16'd65535, 6'h00, 1'b0, 6'h00, 6'h00},
      '{ROW_CSR,  bde_pkg::CSR_ACT_LOW,    16'd0,     6'h00, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h3F, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h00, 1'b0, 6'h00, 6'h00},
      // zero hold: press, double click and held on every button at once
      '{ROW_CSR,  bde_pkg::CSR_HOLD,       16'd0,     6'h00, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h3F, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h00, 1'b0, 6'h00, 6'h00},
      // longest debounce: nothing can change
      '{ROW_CSR,  bde_pkg::CSR_DEBOUNCE,   16'd65535, 6'h00, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h3F, 1'b1, 6'h00, 6'h00},
      // short thresholds, mixed polarity
      '{ROW_CSR,  bde_pkg::CSR_DEBOUNCE,   16'd1,     6'h00, 1'b0, 6'h00, 6'h00},
      '{ROW_CSR,  bde_pkg::CSR_HOLD,       16'd2,     6'h00, 1'b0, 6'h00, 6'h00},
      '{ROW_CSR,  bde_pkg::CSR_DBL_WINDOW, 16'd3,     6'h00, 1'b0, 6'h00, 6'h00},
      '{ROW_CSR,  bde_pkg::CSR_ACT_LOW,    16'h15,    6'h00, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h15, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h2A, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h2A, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h2A, 1'b0, 6'h00, 6'h00},
      // release after held stays silent
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h15, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h2A, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h15, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h2A, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h15, 1'b0, 6'h00, 6'h00},
      // pending click runs out of its window
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h15, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h15, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h15, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h15, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h2A, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h3F, 1'b0, 6'h00, 6'h00},
      '{ROW_TICK, bde_pkg::CSR_DEBOUNCE,   16'd0,     6'h00, 1'b0, 6'h00, 6'h00}
   };

   button_debounce_event_detector u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pin_levels    (req_pin_levels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_valid   (rsp_event_valid),
      .rsp_button_index  (rsp_button_index),
      .rsp_event_code    (rsp_event_code),
      .rsp_hold_duration (rsp_hold_duration),
      .rsp_pressed_mask  (rsp_pressed_mask),
      .rsp_held_mask     (rsp_held_mask),
      .rsp_last_of_tick  (rsp_last_of_tick),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   // Stall the result side at random, never in a calm stretch
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 32);
   end

   task automatic report_mismatch(string what, logic [DUR_W-1:0] got, logic [DUR_W-1:0] want);
      err_count++;
      if (err_count <= MAX_PRINTS)
         $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
   endtask

   function automatic result_type event_item(int b, logic [1:0] code, logic [DUR_W-1:0] dur);
      result_type r;
      r = '0;
      r.event_valid = 1'b1;
      r.button_index = IDX_W'(b);
      r.event_code = code;
      r.hold_duration = dur;
      return r;
   endfunction

   // Advance all buttons by one tick and collect the events it causes
   function automatic void advance_buttons(logic [MASK_W-1:0] lv);
      logic [DUR_W-1:0]  age;
      logic [MASK_W-1:0] pm;
      logic [MASK_W-1:0] hm;
      bit                cur;
      result_type        r;
      tick_events = {};
      pm = '0;
      hm = '0;
      now_tick = now_tick + 1'b1;
      for (int b = 0; b < MASK_W; b++) begin
         cur = lv[b] ^ cfg_act_low[b];
         if (cur != is_pressed[b]) begin
            bounce_cnt[b] = bounce_cnt[b] + 1'b1;
            if (bounce_cnt[b] >= cfg_debounce) begin
               is_pressed[b] = cur;
               bounce_cnt[b] = '0;
               if (cur) begin
                  press_tick[b] = now_tick;
                  held_seen[b] = 1'b0;
                  tick_events.push_back(event_item(b, bde_pkg::EV_PRESSED, '0));
                  age = now_tick - release_tick[b];
                  if (click_open[b] && age <= cfg_window) begin
                     click_open[b] = 1'b0;
                     tick_events.push_back(event_item(b, bde_pkg::EV_DOUBLE, '0));
                  end
               end else begin
                  age = now_tick - press_tick[b];
                  release_tick[b] = now_tick;
                  // a release after held is silent and drops the click
                  if (!held_seen[b]) begin
                     tick_events.push_back(event_item(b, bde_pkg::EV_RELEASED, age));
                     click_open[b] = 1'b1;
                  end else begin
                     click_open[b] = 1'b0;
                  end
                  held_seen[b] = 1'b0;
               end
            end
         end else begin
            bounce_cnt[b] = '0;
         end
         age = now_tick - press_tick[b];
         if (is_pressed[b] && age >= cfg_hold && !held_seen[b]) begin
            held_seen[b] = 1'b1;
            tick_events.push_back(event_item(b, bde_pkg::EV_HELD, age));
         end
         if (click_open[b] && (now_tick - release_tick[b]) > cfg_window)
            click_open[b] = 1'b0;
         if (is_pressed[b]) begin
            pm[b] = 1'b1;
            if (age >= cfg_hold)
               hm[b] = 1'b1;
         end
      end
      if (tick_events.size() == 0) begin
         r = '0;
         tick_events.push_back(r);
      end
      foreach (tick_events[k]) begin
         tick_events[k].pressed_mask = pm;
         tick_events[k].held_mask = hm;
         tick_events[k].last_of_tick = (k == tick_events.size() - 1);
      end
   endfunction

   // Hold requests back until every tick has returned its last result
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (ticks_done != ticks_sent);
   endtask

   task automatic write_csr(logic [CSR_A_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         bde_pkg::CSR_DEBOUNCE: begin
            cfg_debounce = val;
         end
         bde_pkg::CSR_HOLD: begin
            cfg_hold = val;
         end
         bde_pkg::CSR_DBL_WINDOW: begin
            cfg_window = val;
         end
         bde_pkg::CSR_ACT_LOW: begin
            cfg_act_low = val[MASK_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   // Offer one tick, then queue what it should return
   task automatic send_tick(logic [MASK_W-1:0] lv, bit fixed_status,
                            logic [MASK_W-1:0] pm, logic [MASK_W-1:0] hm);
      result_type r;
      while (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pin_levels <= lv;
      do @(posedge clock); while (!req_ready);
      advance_buttons(lv);
      if (fixed_status) begin
         r = '0;
         r.pressed_mask = pm;
         r.held_mask = hm;
         r.last_of_tick = 1'b1;
         tick_events = {r};
      end
      foreach (tick_events[k])
         awaited_events.push_back(tick_events[k]);
      ticks_sent++;
   endtask

   // Set thresholds, then press and release buttons in runs with some bounce
   task automatic run_phase(logic [CNT_W-1:0] deb, logic [CNT_W-1:0] hold,
                            logic [CNT_W-1:0] win, logic [MASK_W-1:0] act_low,
                            int count, bit quiet);
      logic [MASK_W-1:0] target;
      logic [MASK_W-1:0] lv;
      int                run;
      int                hold_span;
      drain();
      write_csr(bde_pkg::CSR_DEBOUNCE, deb);
      write_csr(bde_pkg::CSR_HOLD, hold);
      write_csr(bde_pkg::CSR_DBL_WINDOW, win);
      write_csr(bde_pkg::CSR_ACT_LOW, CSR_W'(act_low));
      calm = quiet;
      target = '0;
      run = 0;
      hold_span = (hold > 20) ? 20 : int'(hold);
      repeat (count) begin
         if (run == 0) begin
            target ^= MASK_W'($urandom_range(1, 63));
            run = int'($urandom_range(1, 2 * int'(deb) + hold_span + 3));
         end
         run--;
         lv = target ^ act_low;
         if ($urandom_range(99) < 10)
            lv[$urandom_range(0, MASK_W - 1)] ^= 1'b1;
         send_tick(lv, 1'b0, '0, '0);
         if ($urandom_range(99) < 2)
            drain();
      end
      calm = 1'b0;
   endtask

   // Compare each returned result with the oldest prediction
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_events.size() == 0) begin
            report_mismatch("result with no tick outstanding",
                            DUR_W'(rsp_button_index), '0);
         end else begin
            want = awaited_events.pop_front();
            if (rsp_event_valid !== want.event_valid)
               report_mismatch("event_valid", DUR_W'(rsp_event_valid),
                               DUR_W'(want.event_valid));
            if (rsp_button_index !== want.button_index)
               report_mismatch("button_index", DUR_W'(rsp_button_index),
                               DUR_W'(want.button_index));
            if (rsp_event_code !== want.event_code)
               report_mismatch("event_code", DUR_W'(rsp_event_code),
                               DUR_W'(want.event_code));
            if (rsp_hold_duration !== want.hold_duration)
               report_mismatch("hold_duration", rsp_hold_duration, want.hold_duration);
            if (rsp_pressed_mask !== want.pressed_mask)
               report_mismatch("pressed_mask", DUR_W'(rsp_pressed_mask),
                               DUR_W'(want.pressed_mask));
            if (rsp_held_mask !== want.held_mask)
               report_mismatch("held_mask", DUR_W'(rsp_held_mask),
                               DUR_W'(want.held_mask));
            if (rsp_last_of_tick !== want.last_of_tick)
               report_mismatch("last_of_tick", DUR_W'(rsp_last_of_tick),
                               DUR_W'(want.last_of_tick));
            if (want.last_of_tick)
               ticks_done++;
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("button_debounce_event_detector test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed plan
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain();
            write_csr(plan[i].index, plan[i].data);
         end else begin
            send_tick(plan[i].levels, plan[i].fixed_status, plan[i].pmask, plan[i].hmask);
         end
      end

      // Random runs under several threshold settings
      run_phase(16'd1, 16'd65535, 16'd65535, 6'h3F, 70, 1'b0);
      run_phase(16'd2, 16'd8, 16'd6, MASK_W'($urandom), 90, 1'b1);
      run_phase(16'd3, 16'd12, 16'd4, MASK_W'($urandom), 80, 1'b0);
      run_phase(CNT_W'($urandom_range(1, 4)), CNT_W'($urandom_range(1, 20)),
                CNT_W'($urandom_range(1, 15)), MASK_W'($urandom), 80, 1'b0);
      run_phase(16'd1, 16'd1, 16'd1, 6'h00, 80, 1'b0);
      run_phase(CNT_W'($urandom_range(1, 3)), CNT_W'($urandom_range(2, 10)),
                CNT_W'($urandom_range(2, 12)), MASK_W'($urandom), 80, 1'b0);

      drain();
      repeat (END_SETTLE) @(posedge clock);
      if (awaited_events.size() != 0)
         report_mismatch("results never returned", DUR_W'(awaited_events.size()), '0);
      if (err_count == 0)
         $display("button_debounce_event_detector test passed");
      else
         $display("button_debounce_event_detector test failed");
      $finish;
   end

endmodule

### sim.f
rtl/bde_pkg.sv
rtl/bde_lane.sv
rtl/bde_merge.sv
rtl/button_debounce_event_detector.sv
tb/sv/tb_top.sv
